/* hw/rtl/mes_pkg.sv */
// monitor entry scheduler: shared types, control word layout and microcode rom
// no dependencies; used by the interfaces, the sequencer, the datapath and the top level
package mes_pkg;

  // fixed payload widths of the request and result items
  localparam int KIND_W = 2;
  localparam int ID_W   = 8;
  localparam int COND_W = 3;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    K_ENTER  = 2'd0,
    K_LEAVE  = 2'd1,
    K_WAIT   = 2'd2,
    K_SIGNAL = 2'd3
  } kind_e;

  // microprogram addresses
  typedef enum logic [4:0] {
    ST_EN_FREE     = 5'd0,
    ST_EN_QUEUE    = 5'd1,
    ST_REQ_FULL    = 5'd2,
    ST_LV_URG      = 5'd3,
    ST_LV_EMIT     = 5'd4,
    ST_LV_ENT      = 5'd5,
    ST_LV_IDLE     = 5'd6,
    ST_REQ_LAST    = 5'd7,
    ST_WT_PUSH     = 5'd8,
    ST_WT_ERR      = 5'd9,
    ST_WT_ERR_LAST = 5'd10,
    ST_HO_URG      = 5'd11,
    ST_HO_EMIT     = 5'd12,
    ST_HO_ENT      = 5'd13,
    ST_HO_IDLE     = 5'd14,
    ST_SG_POP      = 5'd15,
    ST_SG_PARK     = 5'd16,
    ST_SG_FULL     = 5'd17
  } step_e;

  // branch conditions
  typedef enum logic [3:0] {
    J_NONE     = 4'd0,
    J_BUSY     = 4'd1,
    J_ENT_FULL = 4'd2,
    J_URG_NE   = 4'd3,
    J_ENT_NE   = 4'd4,
    J_CPUSH_OK = 4'd5,
    J_CPOP_OK  = 4'd6,
    J_URG_FULL = 4'd7,
    J_HANDON   = 4'd8
  } jcond_e;

  typedef enum logic [1:0] {
    QA_NONE = 2'd0,
    QA_PUSH = 2'd1,
    QA_POP  = 2'd2
  } qact_e;

  typedef enum logic [1:0] {
    QS_ENTRY  = 2'd0,
    QS_URGENT = 2'd1,
    QS_COND   = 2'd2
  } qsel_e;

  typedef enum logic [1:0] {
    OA_NONE = 2'd0,
    OA_REQ  = 2'd1,
    OA_MEM  = 2'd2
  } oact_e;

  // one control word: branch taken skips the action and goes to br
  typedef struct packed {
    jcond_e jc;
    logic   inv;
    step_e  br;
    step_e  nxt;
    logic   fin;
    qact_e  qact;
    qsel_e  qsel;
    oact_e  oact;
    logic   ofull;
    logic   olast;
    logic   bset;
    logic   bclr;
  } uword_t;

  // control word issued to the datapath
  typedef struct packed {
    logic   en;
    uword_t uw;
  } op_t;

  // status returned from the datapath
  typedef struct packed {
    logic busy;
    logic ent_full;
    logic ent_ne;
    logic urg_ne;
    logic urg_full;
    logic cpush_ok;
    logic cpop_ok;
    logic out_stall;
  } flags_t;

  function automatic uword_t uw(jcond_e jc, logic inv, step_e br, step_e nxt, logic fin,
                                qact_e qa, qsel_e qs, oact_e oa, logic ofull,
                                logic olast, logic bset, logic bclr);
    uword_t w;
    w.jc    = jc;
    w.inv   = inv;
    w.br    = br;
    w.nxt   = nxt;
    w.fin   = fin;
    w.qact  = qa;
    w.qsel  = qs;
    w.oact  = oa;
    w.ofull = ofull;
    w.olast = olast;
    w.bset  = bset;
    w.bclr  = bclr;
    return w;
  endfunction

  // first step for each request kind
  function automatic step_e entry_step(kind_e k);
    step_e s;
    unique case (k)
      K_ENTER:  s = ST_EN_FREE;
      K_LEAVE:  s = ST_LV_URG;
      K_WAIT:   s = ST_WT_PUSH;
      K_SIGNAL: s = ST_SG_POP;
      default:  s = ST_EN_FREE;
    endcase
    return s;
  endfunction

  // microprogram
  function automatic uword_t ucode_rom(step_e s);
    uword_t w;
    unique case (s)
      // enter: free monitor is taken at once, else queue or drop
      ST_EN_FREE: w = uw(J_BUSY, 1'b0, ST_EN_QUEUE, ST_EN_FREE, 1'b1,
                         QA_NONE, QS_ENTRY, OA_REQ, 1'b0, 1'b1, 1'b1, 1'b0);
      ST_EN_QUEUE: w = uw(J_ENT_FULL, 1'b0, ST_REQ_FULL, ST_EN_QUEUE, 1'b1,
                          QA_PUSH, QS_ENTRY, OA_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
      ST_REQ_FULL: w = uw(J_NONE, 1'b0, ST_REQ_FULL, ST_REQ_FULL, 1'b1,
                          QA_NONE, QS_ENTRY, OA_REQ, 1'b1, 1'b1, 1'b0, 1'b0);
      // leave: hand on, then release the caller
      ST_LV_URG: w = uw(J_URG_NE, 1'b1, ST_LV_ENT, ST_LV_EMIT, 1'b0,
                        QA_POP, QS_URGENT, OA_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
      ST_LV_EMIT: w = uw(J_NONE, 1'b0, ST_LV_EMIT, ST_REQ_LAST, 1'b0,
                         QA_NONE, QS_ENTRY, OA_MEM, 1'b0, 1'b0, 1'b0, 1'b0);
      ST_LV_ENT: w = uw(J_ENT_NE, 1'b1, ST_LV_IDLE, ST_LV_EMIT, 1'b0,
                        QA_POP, QS_ENTRY, OA_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
      ST_LV_IDLE: w = uw(J_NONE, 1'b0, ST_LV_IDLE, ST_LV_IDLE, 1'b1,
                         QA_NONE, QS_ENTRY, OA_REQ, 1'b0, 1'b1, 1'b0, 1'b1);
      ST_REQ_LAST: w = uw(J_NONE, 1'b0, ST_REQ_LAST, ST_REQ_LAST, 1'b1,
                          QA_NONE, QS_ENTRY, OA_REQ, 1'b0, 1'b1, 1'b0, 1'b0);
      // wait: join the condition queue or drop, then hand on
      ST_WT_PUSH: w = uw(J_CPUSH_OK, 1'b1, ST_WT_ERR, ST_HO_URG, 1'b0,
                         QA_PUSH, QS_COND, OA_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
      ST_WT_ERR: w = uw(J_HANDON, 1'b1, ST_WT_ERR_LAST, ST_HO_URG, 1'b0,
                        QA_NONE, QS_ENTRY, OA_REQ, 1'b1, 1'b0, 1'b0, 1'b0);
      ST_WT_ERR_LAST: w = uw(J_NONE, 1'b0, ST_WT_ERR_LAST, ST_WT_ERR_LAST, 1'b1,
                             QA_NONE, QS_ENTRY, OA_REQ, 1'b1, 1'b1, 1'b0, 1'b1);
      ST_HO_URG: w = uw(J_URG_NE, 1'b1, ST_HO_ENT, ST_HO_EMIT, 1'b0,
                        QA_POP, QS_URGENT, OA_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
      ST_HO_EMIT: w = uw(J_NONE, 1'b0, ST_HO_EMIT, ST_HO_EMIT, 1'b1,
                         QA_NONE, QS_ENTRY, OA_MEM, 1'b0, 1'b1, 1'b0, 1'b0);
      ST_HO_ENT: w = uw(J_ENT_NE, 1'b1, ST_HO_IDLE, ST_HO_EMIT, 1'b0,
                        QA_POP, QS_ENTRY, OA_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
      ST_HO_IDLE: w = uw(J_NONE, 1'b0, ST_HO_IDLE, ST_HO_IDLE, 1'b1,
                         QA_NONE, QS_ENTRY, OA_NONE, 1'b0, 1'b0, 1'b0, 1'b1);
      // signal: wake oldest waiter and park the signaller, else release it
      ST_SG_POP: w = uw(J_CPOP_OK, 1'b1, ST_REQ_LAST, ST_SG_PARK, 1'b0,
                        QA_POP, QS_COND, OA_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
      ST_SG_PARK: w = uw(J_URG_FULL, 1'b0, ST_SG_FULL, ST_SG_PARK, 1'b1,
                         QA_PUSH, QS_URGENT, OA_MEM, 1'b0, 1'b1, 1'b0, 1'b0);
      ST_SG_FULL: w = uw(J_NONE, 1'b0, ST_SG_FULL, ST_REQ_FULL, 1'b0,
                         QA_NONE, QS_ENTRY, OA_MEM, 1'b0, 1'b0, 1'b0, 1'b0);
      default: w = uw(J_NONE, 1'b0, ST_EN_FREE, ST_EN_FREE, 1'b1,
                      QA_NONE, QS_ENTRY, OA_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/mes_req_if.sv */
// request channel of the monitor entry scheduler: valid/ready plus one request item
// depends on mes_pkg for the field widths
interface mes_req_if;
  logic                       valid;
  logic                       ready;
  logic [mes_pkg::KIND_W-1:0] kind;
  logic [mes_pkg::ID_W-1:0]   requester_id;
  logic [mes_pkg::COND_W-1:0] condition_index;

  modport source (output valid, kind, requester_id, condition_index, input ready);
  modport sink (input valid, kind, requester_id, condition_index, output ready);
endinterface

/* hw/rtl/mes_res_if.sv */
// result channel of the monitor entry scheduler: valid/ready plus one result item
// depends on mes_pkg for the field widths
interface mes_res_if;
  logic                     valid;
  logic                     ready;
  logic [mes_pkg::ID_W-1:0] released_id;
  logic                     queue_full;
  logic                     last;

  modport source (output valid, released_id, queue_full, last, input ready);
  modport sink (input valid, released_id, queue_full, last, output ready);
endinterface

/* hw/rtl/mes_useq.sv */
// microcode sequencer: step counter, control rom lookup and conditional branch
// depends on mes_pkg for the control word, flags and rom
module mes_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            acc_i,
  input  mes_pkg::kind_e  kind_i,
  input  mes_pkg::flags_t flags_i,
  output logic            idle_o,
  output mes_pkg::op_t    op_o
);

  logic            run_q, run_d;
  mes_pkg::step_e  step_q, step_d;
  mes_pkg::uword_t word;
  logic            cval;
  logic            taken;
  logic            exec;

  // control word of the current step
  assign word = mes_pkg::ucode_rom(step_q);

  // branch condition select
  always_comb begin
    unique case (word.jc)
      mes_pkg::J_NONE:     cval = 1'b0;
      mes_pkg::J_BUSY:     cval = flags_i.busy;
      mes_pkg::J_ENT_FULL: cval = flags_i.ent_full;
      mes_pkg::J_URG_NE:   cval = flags_i.urg_ne;
      mes_pkg::J_ENT_NE:   cval = flags_i.ent_ne;
      mes_pkg::J_CPUSH_OK: cval = flags_i.cpush_ok;
      mes_pkg::J_CPOP_OK:  cval = flags_i.cpop_ok;
      mes_pkg::J_URG_FULL: cval = flags_i.urg_full;
      mes_pkg::J_HANDON:   cval = flags_i.urg_ne | flags_i.ent_ne;
      default:             cval = 1'b0;
    endcase
  end

  // a step that emits waits while the result register is held
  assign taken = run_q & (cval ^ word.inv);
  assign exec  = run_q & ~taken &
                 ~((word.oact != mes_pkg::OA_NONE) & flags_i.out_stall);

  assign op_o.en = exec;
  assign op_o.uw = word;
  assign idle_o  = ~run_q;

  // step counter
  always_comb begin
    run_d  = run_q;
    step_d = step_q;
    if (acc_i) begin
      run_d  = 1'b1;
      step_d = mes_pkg::entry_step(kind_i);
    end else if (taken) begin
      step_d = word.br;
    end else if (exec) begin
      if (word.fin) begin
        run_d = 1'b0;
      end else begin
        step_d = word.nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= mes_pkg::ST_EN_FREE;
    end else begin
      run_q  <= run_d;
      step_q <= step_d;
    end
  end

endmodule

/* hw/rtl/mes_dpath.sv */
// datapath: busy flag, queue pointers, shared queue memory and result register
// depends on mes_pkg for the control word and flag types
module mes_dpath #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int NUM_CONDITIONS = 8,
  parameter int ID_BITS        = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             acc_i,
  input  logic [mes_pkg::ID_W-1:0]         id_i,
  input  logic [mes_pkg::COND_W-1:0]       cond_i,
  input  mes_pkg::op_t                     op_i,
  input  logic                             out_ready_i,
  output mes_pkg::flags_t                  flags_o,
  output logic                             out_valid_o,
  output logic [mes_pkg::ID_W-1:0]         released_id_o,
  output logic                             queue_full_o,
  output logic                             last_o
);

  localparam int IdW  = mes_pkg::ID_W;
  localparam int SW   = (ID_BITS < IdW) ? ID_BITS : IdW;
  localparam int NCE  = (NUM_CONDITIONS < 8) ? NUM_CONDITIONS : 8;
  localparam int CIW  = (NCE > 1) ? $clog2(NCE) : 1;
  localparam int PW   = $clog2(QUEUE_DEPTH);
  localparam int FW   = $clog2(QUEUE_DEPTH + 1);
  localparam int QIW  = $clog2(NCE + 2);
  localparam int AW   = QIW + PW;
  localparam int MD   = 1 << AW;
  localparam logic [QIW-1:0] QID_ENTRY  = QIW'(0);
  localparam logic [QIW-1:0] QID_URGENT = QIW'(1);
  localparam logic [QIW-1:0] QID_COND0  = QIW'(2);

  // latched request
  logic [SW-1:0]                 id_q;
  logic [mes_pkg::COND_W-1:0]    cond_q;
  logic [CIW-1:0]                cq;
  logic                          cond_ok;

  // queue state
  logic                          busy_q;
  logic [PW-1:0]                 e_head_q, e_tail_q, u_head_q, u_tail_q;
  logic [FW-1:0]                 e_fill_q, u_fill_q;
  logic [PW-1:0]                 c_head_q [NCE];
  logic [PW-1:0]                 c_tail_q [NCE];
  logic [FW-1:0]                 c_fill_q [NCE];

  // shared queue memory
  logic [SW-1:0]                 mem [MD];
  logic [SW-1:0]                 rdata_q;

  // result register
  logic                          out_valid_q, out_valid_d;
  logic [SW-1:0]                 out_id_q;
  logic                          out_full_q, out_last_q;

  logic                          do_push, do_pop, emit;
  logic [QIW-1:0]                qid;
  logic [PW-1:0]                 sel_head, sel_tail;
  logic [AW-1:0]                 addr;
  logic                          sel_e, sel_u, sel_c;

  function automatic logic [PW-1:0] nxt_ptr(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign cq      = cond_q[CIW-1:0];
  assign cond_ok = (int'(cond_q) < NUM_CONDITIONS);

  // decode of the issued control word
  assign do_push = op_i.en & (op_i.uw.qact == mes_pkg::QA_PUSH);
  assign do_pop  = op_i.en & (op_i.uw.qact == mes_pkg::QA_POP);
  assign emit    = op_i.en & (op_i.uw.oact != mes_pkg::OA_NONE);
  assign sel_e   = (op_i.uw.qsel == mes_pkg::QS_ENTRY);
  assign sel_u   = (op_i.uw.qsel == mes_pkg::QS_URGENT);
  assign sel_c   = (op_i.uw.qsel == mes_pkg::QS_COND);

  // queue select: pointers and memory row
  always_comb begin
    unique case (op_i.uw.qsel)
      mes_pkg::QS_ENTRY: begin
        qid      = QID_ENTRY;
        sel_head = e_head_q;
        sel_tail = e_tail_q;
      end
      mes_pkg::QS_URGENT: begin
        qid      = QID_URGENT;
        sel_head = u_head_q;
        sel_tail = u_tail_q;
      end
      default: begin
        qid      = QID_COND0 + QIW'(cq);
        sel_head = c_head_q[cq];
        sel_tail = c_tail_q[cq];
      end
    endcase
  end

  assign addr = do_push ? {qid, sel_tail} : {qid, sel_head};

  // status flags
  assign flags_o.busy      = busy_q;
  assign flags_o.ent_full  = (e_fill_q == FW'(QUEUE_DEPTH));
  assign flags_o.ent_ne    = (e_fill_q != '0);
  assign flags_o.urg_ne    = (u_fill_q != '0);
  assign flags_o.urg_full  = (u_fill_q == FW'(QUEUE_DEPTH));
  assign flags_o.cpush_ok  = cond_ok & (c_fill_q[cq] != FW'(QUEUE_DEPTH));
  assign flags_o.cpop_ok   = cond_ok & (c_fill_q[cq] != '0);
  assign flags_o.out_stall = out_valid_q & ~out_ready_i;

  // request latch
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      id_q   <= id_i[SW-1:0];
      cond_q <= cond_i;
    end
  end

  // queue memory, one access per step
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[addr] <= id_q;
    end
    if (do_pop) begin
      rdata_q <= mem[addr];
    end
  end

  // busy flag and pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      e_head_q <= '0;
      e_tail_q <= '0;
      e_fill_q <= '0;
      u_head_q <= '0;
      u_tail_q <= '0;
      u_fill_q <= '0;
      for (int i = 0; i < NCE; i++) begin
        c_head_q[i] <= '0;
        c_tail_q[i] <= '0;
        c_fill_q[i] <= '0;
      end
    end else begin
      if (op_i.en && op_i.uw.bset) begin
        busy_q <= 1'b1;
      end else if (op_i.en && op_i.uw.bclr) begin
        busy_q <= 1'b0;
      end
      if (do_push && sel_e) begin
        e_tail_q <= nxt_ptr(e_tail_q);
        e_fill_q <= e_fill_q + FW'(1);
      end else if (do_pop && sel_e) begin
        e_head_q <= nxt_ptr(e_head_q);
        e_fill_q <= e_fill_q - FW'(1);
      end
      if (do_push && sel_u) begin
        u_tail_q <= nxt_ptr(u_tail_q);
        u_fill_q <= u_fill_q + FW'(1);
      end else if (do_pop && sel_u) begin
        u_head_q <= nxt_ptr(u_head_q);
        u_fill_q <= u_fill_q - FW'(1);
      end
      if (do_push && sel_c) begin
        c_tail_q[cq] <= nxt_ptr(c_tail_q[cq]);
        c_fill_q[cq] <= c_fill_q[cq] + FW'(1);
      end else if (do_pop && sel_c) begin
        c_head_q[cq] <= nxt_ptr(c_head_q[cq]);
        c_fill_q[cq] <= c_fill_q[cq] - FW'(1);
      end
    end
  end

  // result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_id_q   <= (op_i.uw.oact == mes_pkg::OA_REQ) ? id_q : rdata_q;
      out_full_q <= op_i.uw.ofull;
      out_last_q <= op_i.uw.olast;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign released_id_o = IdW'(out_id_q);
  assign queue_full_o  = out_full_q;
  assign last_o        = out_last_q;

endmodule

/* hw/rtl/monitor_entry_scheduler.sv */
// Monitor entry scheduler (Hoare monitor with urgent queue).
// Request channel req_i: kind (enter, leave, wait, signal), requester_id and
// condition_index. Result channel res_o: released_id, queue_full and last,
// with last set on the final result of a request; a request gives zero to two
// results. Both channels use valid/ready; an item moves when both are high.
// A request is accepted only while the sequencer is idle. It then runs one
// control word per cycle from the microcode rom, 1 to 5 steps, except while a
// step that must emit waits for the output register. The step count is set by
// the branches of the program and the single-ported queue memory, whose read
// data arrive one step after a pop.
// Results go through a one-item output register; the next request is accepted
// while a result waits there. When the receiver stalls, a step that must emit
// holds until the register frees, and the sequencer pauses with it.
// Reset clears the busy flag and all queue pointers and fill counts at once;
// no clearing pass runs, and the block accepts a request in the first cycle
// after reset is released.
// depends on mes_pkg, mes_req_if, mes_res_if, mes_useq and mes_dpath
module monitor_entry_scheduler #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int NUM_CONDITIONS = 8,
  parameter int ID_BITS        = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  mes_req_if.sink        req_i,
  mes_res_if.source      res_o
);

  logic            idle;
  logic            acc;
  mes_pkg::op_t    op;
  mes_pkg::flags_t flags;

  // request handshake
  assign req_i.ready = idle;
  assign acc         = req_i.valid & idle;

  // sequencer
  mes_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .kind_i  (mes_pkg::kind_e'(req_i.kind)),
    .flags_i (flags),
    .idle_o  (idle),
    .op_o    (op)
  );

  // datapath
  mes_dpath #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .NUM_CONDITIONS (NUM_CONDITIONS),
    .ID_BITS        (ID_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (acc),
    .id_i          (req_i.requester_id),
    .cond_i        (req_i.condition_index),
    .op_i          (op),
    .out_ready_i   (res_o.ready),
    .flags_o       (flags),
    .out_valid_o   (res_o.valid),
    .released_id_o (res_o.released_id),
    .queue_full_o  (res_o.queue_full),
    .last_o        (res_o.last)
  );

endmodule

/* sim/tb_monitor_entry_scheduler.sv */
// testbench for monitor_entry_scheduler: predicts released threads and checks each result item
// depends on mes_pkg, mes_req_if, mes_res_if and the monitor_entry_scheduler rtl
`timescale 1ns / 100ps

module tb_monitor_entry_scheduler;

  localparam int QDEPTH   = 16;
  localparam int NUM_COND = 8;
  localparam int ITEMS    = 1700;

  typedef logic [mes_pkg::ID_W-1:0]   tid_t;
  typedef logic [mes_pkg::COND_W-1:0] cond_t;

  // one expected result item
  typedef struct packed {
    tid_t id;
    logic full;
    logic last;
  } release_t;

  // shadow of the monitor state and the queue of releases still to come
  class release_tracker;
    bit       busy_flag;
    tid_t     entry_q[$];
    tid_t     urgent_q[$];
    tid_t     cond_q[NUM_COND][$];
    release_t staged[$];
    release_t release_q[$];
    int       failures;

    function void stage(tid_t id, logic full);
      release_t r;
      r.id   = id;
      r.full = full;
      r.last = 1'b0;
      staged.push_back(r);
    endfunction

    // pass the monitor to the oldest urgent thread, else the oldest entrant
    function void hand_on();
      if (urgent_q.size() > 0) stage(urgent_q.pop_front(), 1'b0);
      else if (entry_q.size() > 0) stage(entry_q.pop_front(), 1'b0);
      else busy_flag = 1'b0;
    endfunction

    function void note_request(mes_pkg::kind_e k, tid_t id, cond_t c);
      bit cond_ok;
      cond_ok = int'(c) < NUM_COND;
      staged = {};
      case (k)
        mes_pkg::K_ENTER: begin
          if (!busy_flag) begin
            busy_flag = 1'b1;
            stage(id, 1'b0);
          end else if (entry_q.size() >= QDEPTH) begin
            stage(id, 1'b1);
          end else begin
            entry_q.push_back(id);
          end
        end
        mes_pkg::K_LEAVE: begin
          hand_on();
          stage(id, 1'b0);
        end
        mes_pkg::K_WAIT: begin
          if (!cond_ok || cond_q[c].size() >= QDEPTH) stage(id, 1'b1);
          else cond_q[c].push_back(id);
          hand_on();
        end
        default: begin
          if (cond_ok && cond_q[c].size() > 0) begin
            stage(cond_q[c].pop_front(), 1'b0);
            if (urgent_q.size() >= QDEPTH) stage(id, 1'b1);
            else urgent_q.push_back(id);
          end else begin
            stage(id, 1'b0);
          end
        end
      endcase
      if (staged.size() > 0) staged[staged.size()-1].last = 1'b1;
      foreach (staged[i]) release_q.push_back(staged[i]);
    endfunction

    function void check_release(tid_t id, logic full, logic last);
      release_t want;
      if (release_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual id %0d full %0b last %0b",
                 $time, id, full, last);
        failures++;
        return;
      end
      want = release_q.pop_front();
      if (id !== want.id) begin
        $display("%0t: released_id expected %0d actual %0d", $time, want.id, id);
        failures++;
      end
      if (full !== want.full) begin
        $display("%0t: queue_full expected %0b actual %0b (id %0d)", $time, want.full, full,
                 want.id);
        failures++;
      end
      if (last !== want.last) begin
        $display("%0t: last expected %0b actual %0b (id %0d)", $time, want.last, last, want.id);
        failures++;
      end
    endfunction

    function int pending();
      return release_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_mode;
  int   recv_mode;
  int   stall_left;
  int   sent;

  release_tracker tracker;

  mes_req_if req_if ();
  mes_res_if res_if ();

  monitor_entry_scheduler u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if.sink),
    .res_o  (res_if.source)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle length: mode 0 none, mode 1 short only, mode 2 mostly short with a few long
  function automatic int pick_gap(int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92 || mode == 1) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
      stall_left <= pick_gap(recv_mode);
    end
  end

  // result check
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready)
      tracker.check_release(res_if.released_id, res_if.queue_full, res_if.last);
  end

  // present one request item and hold it until accepted
  task automatic send_request(mes_pkg::kind_e k, tid_t id, cond_t c);
    int gap;
    gap = pick_gap(send_mode);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid           <= 1'b1;
    req_if.kind            <= k;
    req_if.requester_id    <= id;
    req_if.condition_index <= c;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    tracker.note_request(k, id, c);
    sent++;
  endtask

  // sender holds off until every release has come out
  task automatic wait_all_released();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic send_burst(mes_pkg::kind_e k, int count, cond_t c);
    repeat (count) send_request(k, tid_t'($urandom_range(0, 255)), c);
  endtask

  // stimulus
  initial begin
    int             episode;
    int             pick;
    int             cond_hi;
    cond_t          ca;
    cond_t          cb;
    mes_pkg::kind_e k;

    tracker = new;
    stall_left = 0;
    sent = 0;
    send_mode = 0;
    recv_mode = 0;
    req_if.valid = 1'b0;
    req_if.kind = mes_pkg::K_ENTER;
    req_if.requester_id = '0;
    req_if.condition_index = '0;
    res_if.ready = 1'b0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: free and busy enter, hand-on order, signal with and without waiter,
    // requests out of protocol, id and condition extremes
    send_request(mes_pkg::K_ENTER, 8'h00, 3'd0);
    send_request(mes_pkg::K_ENTER, 8'hff, 3'd7);
    send_request(mes_pkg::K_ENTER, 8'h5a, 3'd0);
    send_request(mes_pkg::K_SIGNAL, 8'h00, 3'd7);
    send_request(mes_pkg::K_WAIT, 8'h00, 3'd7);
    send_request(mes_pkg::K_WAIT, 8'hff, 3'd0);
    send_request(mes_pkg::K_SIGNAL, 8'h5a, 3'd7);
    send_request(mes_pkg::K_LEAVE, 8'h00, 3'd0);
    send_request(mes_pkg::K_SIGNAL, 8'h5a, 3'd0);
    send_request(mes_pkg::K_WAIT, 8'hff, 3'd3);
    send_request(mes_pkg::K_LEAVE, 8'h5a, 3'd7);
    send_request(mes_pkg::K_LEAVE, 8'h11, 3'd0);
    send_request(mes_pkg::K_WAIT, 8'h22, 3'd5);
    send_request(mes_pkg::K_SIGNAL, 8'h33, 3'd3);
    send_request(mes_pkg::K_ENTER, 8'ha5, 3'd2);
    send_request(mes_pkg::K_LEAVE, 8'ha5, 3'd0);
    send_request(mes_pkg::K_SIGNAL, 8'h44, 3'd5);
    send_request(mes_pkg::K_LEAVE, 8'h44, 3'd0);
    send_request(mes_pkg::K_LEAVE, 8'h01, 3'd0);
    wait_all_released();

    // random episodes
    episode = 0;
    while (sent < ITEMS + 19) begin
      send_mode = $urandom_range(0, 2);
      recv_mode = $urandom_range(0, 2);
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        // free mix, sometimes on only a couple of conditions
        cond_hi = $urandom_range(0, 1) ? 7 : 1;
        repeat (40) begin
          pick = $urandom_range(0, 99);
          if (pick < 35) k = mes_pkg::K_ENTER;
          else if (pick < 60) k = mes_pkg::K_LEAVE;
          else if (pick < 80) k = mes_pkg::K_WAIT;
          else k = mes_pkg::K_SIGNAL;
          send_request(k, tid_t'($urandom_range(0, 255)), cond_t'($urandom_range(0, cond_hi)));
        end
      end else if (pick < 8) begin
        // overrun the entry queue, then drain it
        send_burst(mes_pkg::K_ENTER, 19, cond_t'($urandom_range(0, 7)));
        send_burst(mes_pkg::K_LEAVE, 19, cond_t'($urandom_range(0, 7)));
      end else begin
        // overrun one condition queue, then the urgent queue, then drain
        ca = cond_t'($urandom_range(0, 7));
        cb = cond_t'((int'(ca) + 1 + $urandom_range(0, 6)) % NUM_COND);
        send_burst(mes_pkg::K_WAIT, 17, ca);
        send_burst(mes_pkg::K_WAIT, 16, cb);
        send_burst(mes_pkg::K_SIGNAL, 17, ca);
        send_burst(mes_pkg::K_SIGNAL, 1, cb);
        send_burst(mes_pkg::K_LEAVE, 18, ca);
      end
      if ($urandom_range(0, 3) == 0) wait_all_released();
      episode++;
    end

    // drain
    req_if.valid <= 1'b0;
    recv_mode = 1;
    for (int n = 0; n < 100000 && tracker.pending() != 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.pending() != 0) begin
      $display("%0t: %0d results expected but never seen", $time, tracker.pending());
      tracker.failures++;
    end
    if (tracker.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
